/* rtl/line_id_order_table_macros.svh */
// assertion helpers for the line id order table
// each expands to one labeled concurrent assertion clocked on clk, off during reset
`ifndef LINE_ID_ORDER_TABLE_MACROS_SVH
`define LINE_ID_ORDER_TABLE_MACROS_SVH

// same-cycle implication
`define LIDT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LIDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lidt_pkg.sv */
`timescale 1ns / 1ps
package lidt_pkg;

	localparam int OP_W    = 3;
	localparam int KEY_W   = 6;
	localparam int POS_W   = 6;
	localparam int LINES_W = 6;

	localparam logic [POS_W-1:0]   POS_MAX     = 6'd63;
	localparam logic [LINES_W-1:0] RESET_LINES = 6'd37;

	// request opcodes
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
	localparam logic [OP_W-1:0] OP_REV    = 3'd1;
	localparam logic [OP_W-1:0] OP_FREE   = 3'd2;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
	localparam logic [OP_W-1:0] OP_INIT   = 3'd5;

	// one response
	typedef struct packed {
		logic             ok;
		logic [POS_W-1:0] value;
	} rsp_t;

endpackage

/* rtl/lidt_ifs.sv */
`timescale 1ns / 1ps
// request channel
interface lidt_req_if;
	import lidt_pkg::*;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [KEY_W-1:0] key;
	modport source (output valid, output opcode, output key, input ready);
	modport sink (input valid, input opcode, input key, output ready);
endinterface

// response channel
interface lidt_rsp_if;
	import lidt_pkg::*;
	logic             valid;
	logic             ready;
	logic             ok;
	logic [POS_W-1:0] value;
	modport source (output valid, output ok, output value, input ready);
	modport sink (input valid, input ok, input value, output ready);
endinterface

// configuration write channel
interface lidt_cfg_if;
	import lidt_pkg::*;
	logic               valid;
	logic               ready;
	logic [LINES_W-1:0] initial_lines;
	modport source (output valid, output initial_lines, input ready);
	modport sink (input valid, input initial_lines, output ready);
endinterface

/* rtl/lidt_mem.sv */
`timescale 1ns / 1ps
module lidt_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [lidt_pkg::POS_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [lidt_pkg::POS_W-1:0] rdata
);
	import lidt_pkg::*;

	logic [POS_W-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/lidt_ctrl.sv */
`timescale 1ns / 1ps
module lidt_ctrl #(
	parameter int TABLE_DEPTH = 64,
	parameter int AW          = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [lidt_pkg::OP_W-1:0]    opcode,
	input  logic [lidt_pkg::KEY_W-1:0]   key,
	input  logic [lidt_pkg::LINES_W-1:0] lines,
	output logic                         resp_valid,
	input  logic                         resp_take,
	output lidt_pkg::rsp_t               resp,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic [lidt_pkg::POS_W-1:0]   mem_wdata,
	output logic                         mem_re,
	output logic [AW-1:0]                mem_raddr,
	input  logic [lidt_pkg::POS_W-1:0]   mem_rdata
);
	import lidt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_UPDATE = 5'b00100,
		ST_INIT   = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

	localparam logic [AW-1:0] LAST_ID = AW'(TABLE_DEPTH - 1);
	localparam int CW = (AW > LINES_W) ? AW : LINES_W;

	state_t           state_q;
	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic [AW-1:0]    idx_q;
	logic             issue_done_q;
	logic             from_reset_q;
	logic             found_q;
	logic             ovf_q;
	logic [AW-1:0]    fresh_q;
	logic [POS_W-1:0] p_q;
	rsp_t             resp_q;
	logic             vld_s1;
	logic             last_s1;
	logic [AW-1:0]    addr_s1;

	logic               key_valid;
	logic [AW-1:0]      key_id;
	logic [POS_W-1:0]   target;
	logic               issuing;
	logic               scan_end;
	logic               match_now;
	logic               found_d;
	logic [AW-1:0]      fresh_d;
	logic [POS_W-1:0]   p_d;
	logic               ovf_d;
	logic               do_update;
	logic [POS_W-1:0]   new_pos;
	logic [LINES_W-1:0] init_lines;
	logic [POS_W-1:0]   init_val;

	// key decode and scan target
	assign key_valid = (int'(key_q) < TABLE_DEPTH);
	assign key_id    = AW'(key_q);
	assign target    = (op_q == OP_REV) ? POS_W'(key_q) : '0;

	// sweep reads over ids 1 .. depth-1
	assign issuing   = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && !issue_done_q;
	assign mem_re    = issuing;
	assign mem_raddr = idx_q;
	assign scan_end  = vld_s1 && last_s1;

	// scan accumulation on returning read data
	assign match_now = vld_s1 && !found_q && (mem_rdata == target);
	assign found_d   = found_q || match_now;
	assign fresh_d   = match_now ? addr_s1 : fresh_q;
	assign p_d       = (vld_s1 && key_valid && (addr_s1 == key_id)) ? mem_rdata : p_q;
	assign ovf_d     = ovf_q || (vld_s1 && (mem_rdata == POS_MAX));
	assign do_update = ((op_q == OP_INSERT) && (p_d != '0) && found_d && !ovf_d) ||
	                   ((op_q == OP_DELETE) && (p_d != '0));

	// modified position for the update pass
	always_comb begin
		new_pos = mem_rdata;
		if (op_q == OP_INSERT) begin
			if (addr_s1 == fresh_q) begin
				new_pos = p_q;
			end else if (addr_s1 == key_id) begin
				new_pos = p_q + POS_W'(1);
			end else if (mem_rdata > p_q) begin
				new_pos = mem_rdata + POS_W'(1);
			end
		end else begin
			if (addr_s1 == key_id) begin
				new_pos = '0;
			end else if (mem_rdata > p_q) begin
				new_pos = mem_rdata - POS_W'(1);
			end
		end
	end

	// initialize pass value
	assign init_lines = from_reset_q ? RESET_LINES : lines;
	assign init_val   = (CW'(idx_q) <= CW'(init_lines)) ? POS_W'(idx_q) : '0;

	// memory write port
	assign mem_we    = ((state_q == ST_UPDATE) && vld_s1) || (state_q == ST_INIT);
	assign mem_waddr = (state_q == ST_INIT) ? idx_q : addr_s1;
	assign mem_wdata = (state_q == ST_INIT) ? init_val : new_pos;

	assign req_ready  = (state_q == ST_IDLE);
	assign resp_valid = (state_q == ST_RESP);
	assign resp       = resp_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			from_reset_q <= 1'b1;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			found_q      <= 1'b0;
			ovf_q        <= 1'b0;
			vld_s1       <= 1'b0;
			last_s1      <= 1'b0;
		end else begin
			vld_s1  <= issuing;
			last_s1 <= issuing && (idx_q == LAST_ID);
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						idx_q        <= AW'(1);
						issue_done_q <= 1'b0;
						found_q      <= 1'b0;
						ovf_q        <= 1'b0;
						case (opcode)
							OP_LOOKUP, OP_REV, OP_FREE, OP_INSERT, OP_DELETE: begin
								state_q <= ST_SCAN;
							end
							OP_INIT: begin
								idx_q   <= '0;
								state_q <= ST_INIT;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						idx_q <= idx_q + AW'(1);
						if (idx_q == LAST_ID) begin
							issue_done_q <= 1'b1;
						end
					end
					found_q <= found_d;
					ovf_q   <= ovf_d;
					if (scan_end) begin
						if (do_update) begin
							idx_q        <= AW'(1);
							issue_done_q <= 1'b0;
							state_q      <= ST_UPDATE;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_UPDATE: begin
					if (issuing) begin
						idx_q <= idx_q + AW'(1);
						if (idx_q == LAST_ID) begin
							issue_done_q <= 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= ST_RESP;
					end
				end
				ST_INIT: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == LAST_ID) begin
						from_reset_q <= 1'b0;
						state_q      <= from_reset_q ? ST_IDLE : ST_RESP;
					end
				end
				ST_RESP: begin
					if (resp_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request fields, scan results and response
	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
		if ((state_q == ST_IDLE) && req_valid) begin
			op_q   <= opcode;
			key_q  <= key;
			p_q    <= '0;
			resp_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			fresh_q <= fresh_d;
			p_q     <= p_d;
			if (scan_end) begin
				case (op_q)
					OP_LOOKUP: begin
						resp_q.ok    <= (p_d != '0);
						resp_q.value <= p_d;
					end
					OP_REV, OP_FREE: begin
						resp_q.ok    <= found_d;
						resp_q.value <= found_d ? POS_W'(fresh_d) : '0;
					end
					default: begin
						resp_q <= '0;
					end
				endcase
			end
		end
		if ((state_q == ST_UPDATE) && scan_end) begin
			resp_q.ok    <= 1'b1;
			resp_q.value <= '0;
		end
		if ((state_q == ST_INIT) && (idx_q == LAST_ID)) begin
			resp_q.ok    <= 1'b1;
			resp_q.value <= '0;
		end
	end

endmodule

/* rtl/line_id_order_table.sv */
`timescale 1ns / 1ps
// Line id order table: keeps the line position of every id 1..TABLE_DEPTH-1 (0 = free) in one
// single-port-write, registered-read memory and serves one request at a time. Every request
// except initialize and unused opcodes first sweeps the whole table, one entry per cycle; a
// successful insert or delete adds a read-modify-write sweep; initialize writes every entry; an
// unused opcode answers without a sweep. After reset the table is loaded with its default
// contents in a pass during which no request is taken (configuration writes still are). A
// finished response sits in an output register, so the next request may start while it waits.
`include "line_id_order_table_macros.svh"
module line_id_order_table #(
	parameter int TABLE_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	lidt_req_if.sink   req,
	lidt_rsp_if.source rsp,
	lidt_cfg_if.sink   cfg
);
	import lidt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [LINES_W-1:0] lines_q;
	logic               out_valid_q;
	rsp_t               out_q;

	logic             resp_valid;
	logic             resp_take;
	rsp_t             resp;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [POS_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [POS_W-1:0] mem_rdata;

	// configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= RESET_LINES;
		end else if (cfg.valid) begin
			lines_q <= cfg.initial_lines;
		end
	end

	lidt_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.opcode     (req.opcode),
		.key        (req.key),
		.lines      (lines_q),
		.resp_valid (resp_valid),
		.resp_take  (resp_take),
		.resp       (resp),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	lidt_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register
	assign resp_take = resp_valid && (!out_valid_q || rsp.ready);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_take) begin
			out_q <= resp;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.ok    = out_q.ok;
	assign rsp.value = out_q.value;

	// checks
	`LIDT_ASSERT_SAME(a_no_write_idle, mem_we, !req.ready, "table written while idle")
	`LIDT_ASSERT_SAME(a_no_rw_same, mem_we && mem_re, mem_waddr != mem_raddr, "read/write same entry")
	`LIDT_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready, "request overlap")
	`LIDT_ASSERT_NEXT(a_resp_loaded, resp_take, rsp.valid, "response not presented")

endmodule

/* test/tb_line_id_order_table.sv */
`timescale 1ns / 1ps
module tb_line_id_order_table;
	import lidt_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 10;
	localparam int REPORT_MAX   = 10;

	// opcodes the block leaves unused
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

	typedef struct {
		logic [OP_W-1:0]  opcode;
		logic [KEY_W-1:0] key;
		int unsigned      gap;
	} line_request_t;

	logic clk;
	logic arst_n;

	lidt_req_if req_ch ();
	lidt_rsp_if rsp_ch ();
	lidt_cfg_if cfg_ch ();

	line_id_order_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// shadow of the id table and the initialize length
	logic [POS_W-1:0]   line_pos [TABLE_DEPTH];
	logic [LINES_W-1:0] table_lines;

	line_request_t pending_requests [$];
	rsp_t          expected_responses [$];
	line_request_t next_request;
	rsp_t          oldest_response;
	int unsigned   gap_left;
	int unsigned   stall_left;
	int unsigned   mismatches;
	int unsigned   cycles;
	bit            no_idle;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// table after initialize
	function automatic void load_table();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			line_pos[i] = (i != 0 && i <= table_lines) ? POS_W'(i) : '0;
		end
	endfunction

	// smallest id holding a given position, 0 if none
	function automatic logic [KEY_W-1:0] first_id_at(input logic [POS_W-1:0] pos);
		for (int j = 1; j < TABLE_DEPTH; j++) begin
			if (line_pos[j] == pos) return KEY_W'(j);
		end
		return '0;
	endfunction

	// apply one request to the shadow table and return its response
	function automatic rsp_t apply_request(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] key);
		rsp_t             r;
		logic [POS_W-1:0] p;
		logic [KEY_W-1:0] fresh;
		bit               at_top;
		r = '0;
		p = (key == 0) ? '0 : line_pos[key];
		case (op)
			OP_LOOKUP: begin
				r.value = p;
				r.ok    = (p != 0);
			end
			OP_REV: begin
				r.value = first_id_at(key);
				r.ok    = (r.value != 0);
			end
			OP_FREE: begin
				r.value = first_id_at('0);
				r.ok    = (r.value != 0);
			end
			OP_INSERT: begin
				fresh  = first_id_at('0);
				at_top = 1'b0;
				for (int i = 1; i < TABLE_DEPTH; i++) begin
					if (line_pos[i] == POS_MAX) at_top = 1'b1;
				end
				if (p != 0 && fresh != 0 && !at_top) begin
					// push later lines down, new id takes the old spot
					for (int i = 1; i < TABLE_DEPTH; i++) begin
						if (i != fresh && i != key && line_pos[i] > p) line_pos[i]++;
					end
					line_pos[fresh] = p;
					line_pos[key]   = p + 1'b1;
					r.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (p != 0) begin
					// pull later lines up
					for (int i = 1; i < TABLE_DEPTH; i++) begin
						if (i != key && line_pos[i] > p) line_pos[i]--;
					end
					line_pos[key] = '0;
					r.ok = 1'b1;
				end
			end
			OP_INIT: begin
				load_table();
				r.ok = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// random idle length, mostly short, now and then long
	function automatic int unsigned pick_idle();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 45);
	endfunction

	function automatic logic [KEY_W-1:0] pick_id();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 6) return '0;
		if (r < 10) return '1;
		return KEY_W'($urandom_range(1, TABLE_DEPTH - 1));
	endfunction

	task automatic queue_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
		line_request_t it;
		it.opcode = op;
		it.key    = key;
		it.gap    = pick_idle();
		pending_requests.push_back(it);
	endtask

	// wait until every request went out and every response came back
	task automatic drain();
		while (pending_requests.size() != 0 || req_ch.valid || expected_responses.size() != 0)
			@(negedge clk);
	endtask

	// write the initialize length while the block is idle
	task automatic set_lines(input logic [LINES_W-1:0] lines);
		drain();
		@(posedge clk);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.initial_lines <= lines;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		table_lines = lines;
		cfg_ch.valid <= 1'b0;
	endtask

	// initialize, then a random mix weighted toward growing or shrinking
	task automatic random_phase(input logic [LINES_W-1:0] lines, input int count,
			input int insert_pct, input int delete_pct, input bit quiet);
		int unsigned r;
		int unsigned s;
		set_lines(lines);
		no_idle = quiet;
		queue_request(OP_INIT, KEY_W'($urandom_range(0, 63)));
		for (int n = 1; n < count; n++) begin
			r = $urandom_range(0, 99);
			s = $urandom_range(0, 99);
			if (r < insert_pct)
				queue_request(OP_INSERT, pick_id());
			else if (r < insert_pct + delete_pct)
				queue_request(OP_DELETE, pick_id());
			else if (s < 35)
				queue_request(OP_LOOKUP, pick_id());
			else if (s < 70)
				queue_request(OP_REV, (s < 40) ? '0 : KEY_W'($urandom_range(1, 63)));
			else if (s < 87)
				queue_request(OP_FREE, KEY_W'($urandom_range(0, 63)));
			else if (s < 92)
				queue_request(OP_INIT, KEY_W'($urandom_range(0, 63)));
			else
				queue_request(s[0] ? OP_SPARE7 : OP_SPARE6, KEY_W'($urandom_range(0, 63)));
		end
	endtask

	// request driver: predicts on accept, then presents the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_responses.push_back(apply_request(req_ch.opcode, req_ch.key));
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					next_request = pending_requests.pop_front();
					req_ch.valid  <= 1'b1;
					req_ch.opcode <= next_request.opcode;
					req_ch.key    <= next_request.key;
					gap_left = next_request.gap;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_response(input logic got_ok, input logic [POS_W-1:0] got_value);
		if (expected_responses.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("unexpected response ok=%0b value=%0d", got_ok, got_value);
		end else begin
			oldest_response = expected_responses.pop_front();
			if (got_ok !== oldest_response.ok || got_value !== oldest_response.value) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("response mismatch: expected ok=%0b value=%0d, got ok=%0b value=%0d",
						oldest_response.ok, oldest_response.value, got_ok, got_value);
			end
		end
	endtask

	// response monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) check_response(rsp_ch.ok, rsp_ch.value);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall_left = pick_idle();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_line_id_order_table: errors");
			$finish;
		end
	end

	// reset, stimulus and end of run
	initial begin
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.opcode        = OP_LOOKUP;
		req_ch.key           = '0;
		rsp_ch.ready         = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.initial_lines = '0;
		no_idle              = 1'b0;
		mismatches           = 0;
		cycles               = 0;
		table_lines          = RESET_LINES;
		load_table();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// table as it comes out of reset
		queue_request(OP_LOOKUP, 6'd0);
		queue_request(OP_LOOKUP, 6'd63);
		queue_request(OP_LOOKUP, 6'd37);
		queue_request(OP_REV, 6'd0);
		queue_request(OP_REV, 6'd63);
		queue_request(OP_REV, 6'd1);
		queue_request(OP_FREE, 6'd21);
		queue_request(OP_INSERT, 6'd0);
		queue_request(OP_INSERT, 6'd50);
		queue_request(OP_INSERT, 6'd1);
		queue_request(OP_DELETE, 6'd0);
		queue_request(OP_DELETE, 6'd63);
		queue_request(OP_DELETE, 6'd37);
		queue_request(OP_LOOKUP, 6'd1);
		queue_request(OP_SPARE6, 6'd5);
		queue_request(OP_SPARE7, 6'd63);
		queue_request(OP_INIT, 6'd0);

		// full table
		set_lines(6'd63);
		queue_request(OP_INIT, 6'd42);
		queue_request(OP_INSERT, 6'd5);
		queue_request(OP_FREE, 6'd0);
		queue_request(OP_REV, 6'd0);
		queue_request(OP_REV, 6'd63);
		queue_request(OP_DELETE, 6'd63);
		queue_request(OP_FREE, 6'd0);
		queue_request(OP_INSERT, 6'd10);
		queue_request(OP_LOOKUP, 6'd63);

		random_phase(6'd37, 260, 35, 25, 1'b0);
		random_phase(6'd0, 120, 30, 20, 1'b1);
		random_phase(6'd63, 260, 20, 40, 1'b0);
		random_phase(6'd1, 260, 45, 15, 1'b0);
		random_phase(LINES_W'($urandom_range(0, 63)), 240, 30, 30, 1'b1);
		random_phase(6'd62, 260, 35, 25, 1'b0);
		random_phase(LINES_W'($urandom_range(0, 63)), 260, 30, 30, 1'b0);
		random_phase(6'd37, 240, 40, 20, 1'b0);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_line_id_order_table: clean");
		else
			$display("tb_line_id_order_table: errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/lidt_pkg.sv
rtl/lidt_ifs.sv
rtl/lidt_mem.sv
rtl/lidt_ctrl.sv
rtl/line_id_order_table.sv
test/tb_line_id_order_table.sv
